### rtl/core/acds_pkg.sv
// shared constants, codes and types for the audio chunk drop speedup block
package acds_pkg;

    localparam int CHUNK_MAX   = 4096;
    localparam int CHANNEL_MAX = 8;
    localparam int FADE_MAX    = 2048;
    localparam int SAMPLE_BITS = 16;

    localparam int FRAME_W   = $clog2(CHUNK_MAX);
    localparam int CHAN_W    = $clog2(CHANNEL_MAX);
    localparam int SLOT_W    = $clog2(FADE_MAX);
    localparam int HADDR_W   = SLOT_W + CHAN_W;
    localparam int HELD_DEPTH = FADE_MAX * CHANNEL_MAX;
    localparam int CNT_W     = 15;
    localparam int GAIN_W    = 16;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 13;
    localparam int CH_CFG_W  = 4;
    localparam int S_DATA_W  = 48;
    localparam int M_DATA_W  = 32;
    localparam int OP_W      = 3;

    localparam logic [GAIN_W-1:0] UNITY_GAIN = 16'h8000;

    localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GAIN   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP     = 2'd2;

    localparam logic [OP_W-1:0] OP_EMIT  = 3'd0;
    localparam logic [OP_W-1:0] OP_HOLD  = 3'd1;
    localparam logic [OP_W-1:0] OP_BLEND = 3'd2;
    localparam logic [OP_W-1:0] OP_END   = 3'd3;
    localparam logic [OP_W-1:0] OP_GAIN  = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]               op;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [HADDR_W-1:0]            addr;
        logic [GAIN_W-1:0]             gain;
        logic [CNT_W-1:0]              count;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

### rtl/core/acds_front.sv
// front end: config registers, chunk position tracking and item classification
module acds_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [acds_pkg::S_DATA_W-1:0] i_s_tdata,
    input  logic [acds_pkg::KIND_W-1:0]   i_s_tuser,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [acds_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [acds_pkg::CFG_W-1:0]    i_cfg_data,
    input  acds_pkg::t_fifo_stat          i_fifo_stat,
    output logic                          o_push,
    output acds_pkg::t_cmd                o_cmd
);
    import acds_pkg::*;

    logic [CH_CFG_W-1:0] r_ch_cfg, n_ch_cfg;
    logic [CFG_W-1:0]    r_chunk_cfg, n_chunk_cfg;
    logic [CFG_W-1:0]    r_keep_cfg, n_keep_cfg;
    logic [FRAME_W-1:0]  r_frame, n_frame;
    logic [CHAN_W-1:0]   r_chan, n_chan;
    logic [CNT_W-1:0]    r_emitted, n_emitted;

    logic [CH_CFG_W-1:0]    w_ch_cl;
    logic [CHAN_W-1:0]      w_ch_last;
    logic [CFG_W-1:0]       w_chunk_cl, w_keep_cl, w_drop, w_fade;
    logic [CFG_W-1:0]       w_hold_start, w_tail_start, w_frame_ext;
    logic [SLOT_W-1:0]      w_j_hold, w_j_tail;
    logic                   w_accept, w_chan_end, w_frame_end, w_emit;
    logic signed [SAMPLE_BITS-1:0] w_sample;
    logic [SLOT_W-1:0]      w_slot;
    logic [GAIN_W-1:0]      w_gain_in;

    assign o_s_tready  = !i_fifo_stat.full;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_s_tvalid && o_s_tready;

    // tdata: sample_in, gain_slot, gain_value
    assign w_sample  = i_s_tdata[SAMPLE_BITS-1:0];
    assign w_slot    = i_s_tdata[SAMPLE_BITS +: SLOT_W];
    assign w_gain_in = i_s_tdata[SAMPLE_BITS + SLOT_W +: GAIN_W];

    always_comb begin
        if (r_ch_cfg == '0) begin
            w_ch_cl = CH_CFG_W'(1);
        end else if (r_ch_cfg > CH_CFG_W'(CHANNEL_MAX)) begin
            w_ch_cl = CH_CFG_W'(CHANNEL_MAX);
        end else begin
            w_ch_cl = r_ch_cfg;
        end
        w_ch_last = CHAN_W'(w_ch_cl - CH_CFG_W'(1));

        if (r_chunk_cfg == '0) begin
            w_chunk_cl = CFG_W'(1);
        end else if (r_chunk_cfg > CFG_W'(CHUNK_MAX)) begin
            w_chunk_cl = CFG_W'(CHUNK_MAX);
        end else begin
            w_chunk_cl = r_chunk_cfg;
        end

        if (r_keep_cfg == '0) begin
            w_keep_cl = CFG_W'(1);
        end else if (r_keep_cfg > w_chunk_cl) begin
            w_keep_cl = w_chunk_cl;
        end else begin
            w_keep_cl = r_keep_cfg;
        end

        w_drop       = w_chunk_cl - w_keep_cl;
        w_fade       = (w_keep_cl < w_drop) ? w_keep_cl : w_drop;
        w_hold_start = w_keep_cl - w_fade;
        w_tail_start = w_chunk_cl - w_fade;
        w_frame_ext  = CFG_W'(r_frame);
        w_j_hold     = SLOT_W'(w_frame_ext - w_hold_start);
        w_j_tail     = SLOT_W'(w_frame_ext - w_tail_start);
        w_chan_end   = (r_chan == w_ch_last);
        w_frame_end  = (w_frame_ext == w_chunk_cl - CFG_W'(1));
    end

    always_comb begin
        n_ch_cfg    = r_ch_cfg;
        n_chunk_cfg = r_chunk_cfg;
        n_keep_cfg  = r_keep_cfg;
        n_frame     = r_frame;
        n_chan      = r_chan;
        n_emitted   = r_emitted;
        o_push      = 1'b0;
        o_cmd       = '0;
        o_cmd.sample = w_sample;
        w_emit      = 1'b0;

        if (w_accept) begin
            unique case (i_s_tuser)
                KIND_GAIN: begin
                    o_push     = 1'b1;
                    o_cmd.op   = OP_GAIN;
                    o_cmd.addr = {w_slot, {CHAN_W{1'b0}}};
                    o_cmd.gain = (w_gain_in > UNITY_GAIN) ? UNITY_GAIN : w_gain_in;
                end
                KIND_END: begin
                    o_push      = 1'b1;
                    o_cmd.op    = OP_END;
                    o_cmd.count = r_emitted;
                    n_frame     = '0;
                    n_chan      = '0;
                    n_emitted   = '0;
                end
                KIND_SAMPLE: begin
                    if (w_frame_ext < w_hold_start) begin
                        o_push   = 1'b1;
                        o_cmd.op = OP_EMIT;
                        w_emit   = 1'b1;
                    end else if (w_frame_ext < w_keep_cl) begin
                        o_push     = 1'b1;
                        o_cmd.op   = OP_HOLD;
                        o_cmd.addr = {w_j_hold, r_chan};
                    end else if (w_frame_ext >= w_tail_start) begin
                        o_push     = 1'b1;
                        o_cmd.op   = OP_BLEND;
                        o_cmd.addr = {w_j_tail, r_chan};
                        w_emit     = 1'b1;
                    end
                    n_emitted = r_emitted + CNT_W'(w_emit);
                    if (w_chan_end) begin
                        n_chan = '0;
                        if (w_frame_end) begin
                            n_frame   = '0;
                            n_emitted = '0;
                        end else begin
                            n_frame = r_frame + FRAME_W'(1);
                        end
                    end else begin
                        n_chan = r_chan + CHAN_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CHANNELS: n_ch_cfg    = i_cfg_data[CH_CFG_W-1:0];
                CFG_CHUNK:    n_chunk_cfg = i_cfg_data;
                CFG_KEEP:     n_keep_cfg  = i_cfg_data;
                default: begin
                end
            endcase
            if (i_cfg_index == CFG_CHANNELS || i_cfg_index == CFG_CHUNK ||
                i_cfg_index == CFG_KEEP) begin
                n_frame   = '0;
                n_chan    = '0;
                n_emitted = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch_cfg    <= CH_CFG_W'(1);
            r_chunk_cfg <= CFG_W'(1024);
            r_keep_cfg  <= CFG_W'(512);
            r_frame     <= '0;
            r_chan      <= '0;
            r_emitted   <= '0;
        end else begin
            r_ch_cfg    <= n_ch_cfg;
            r_chunk_cfg <= n_chunk_cfg;
            r_keep_cfg  <= n_keep_cfg;
            r_frame     <= n_frame;
            r_chan      <= n_chan;
            r_emitted   <= n_emitted;
        end
    end

endmodule

### rtl/core/acds_cmd_fifo.sv
// short command queue between the front end and the back end
module acds_cmd_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  acds_pkg::t_cmd       i_cmd,
    input  logic                 i_pop,
    output acds_pkg::t_cmd       o_cmd,
    output acds_pkg::t_fifo_stat o_stat
);
    import acds_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [PTR_W:0]   r_count, n_count;
    logic             w_push, w_pop;

    assign o_stat.full  = (r_count == (PTR_W+1)'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_cmd        = r_mem[r_rd_ptr];
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;

    always_comb begin
        n_wr_ptr = w_push ? r_wr_ptr + PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = w_pop ? r_rd_ptr + PTR_W'(1) : r_rd_ptr;
        n_count  = r_count + (PTR_W+1)'(w_push) - (PTR_W+1)'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### rtl/core/acds_back.sv
// back end: fade table, hold buffer, crossfade pipeline and output register
module acds_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  acds_pkg::t_cmd                i_cmd,
    input  acds_pkg::t_fifo_stat          i_fifo_stat,
    output logic                          o_pop,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [acds_pkg::M_DATA_W-1:0] o_m_tdata,
    output logic                          o_m_tuser
);
    import acds_pkg::*;

    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int PROD_W = DIFF_W + GAIN_W + 1;
    localparam int ACC_W  = PROD_W + 1;
    localparam int RND    = 15;

    logic [GAIN_W-1:0]             r_gain_mem [FADE_MAX];
    logic signed [SAMPLE_BITS-1:0] r_held_mem [HELD_DEPTH];

    logic                          w_adv;
    logic                          r_s1_valid, r_s2_valid, r_out_valid;
    t_cmd                          r_s1_cmd;
    logic [OP_W-1:0]               r_s2_op;
    logic signed [SAMPLE_BITS-1:0] r_s2_sample, r_s2_held;
    logic [CNT_W-1:0]              r_s2_count;
    logic signed [PROD_W-1:0]      r_s2_prod;
    logic [GAIN_W-1:0]             r_s1_gain;
    logic signed [SAMPLE_BITS-1:0] r_s1_held;

    logic signed [DIFF_W-1:0]      w_diff;
    logic signed [PROD_W-1:0]      w_prod;
    logic signed [ACC_W-1:0]       w_acc;
    logic signed [ACC_W-RND-1:0]   w_shift;
    logic signed [SAMPLE_BITS-1:0] w_blend;
    logic                          w_has_result;

    logic signed [SAMPLE_BITS-1:0] r_out_sample;
    logic                          r_out_end;
    logic [CNT_W-1:0]              r_out_count;

    assign w_adv = !r_out_valid || i_m_tready;
    assign o_pop = w_adv && !i_fifo_stat.empty;

    // fade table and hold buffer, read data registered
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (o_pop && i_cmd.op == OP_GAIN) begin
                r_gain_mem[i_cmd.addr[HADDR_W-1:CHAN_W]] <= i_cmd.gain;
            end
            r_s1_gain <= r_gain_mem[i_cmd.addr[HADDR_W-1:CHAN_W]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (o_pop && i_cmd.op == OP_HOLD) begin
                r_held_mem[i_cmd.addr] <= i_cmd.sample;
            end
            r_s1_held <= r_held_mem[i_cmd.addr];
        end
    end

    always_comb begin
        w_diff = DIFF_W'(r_s1_cmd.sample) - DIFF_W'(r_s1_held);
        w_prod = PROD_W'(w_diff) * $signed(PROD_W'({1'b0, r_s1_gain}));
        w_acc  = (ACC_W'(r_s2_held) <<< RND) + ACC_W'(r_s2_prod)
               + ACC_W'(1 << (RND - 1));
        w_shift = w_acc[ACC_W-1:RND];
        if (w_shift > (ACC_W-RND)'(32767)) begin
            w_blend = 16'sh7fff;
        end else if (w_shift < -(ACC_W-RND)'(32768)) begin
            w_blend = 16'sh8000;
        end else begin
            w_blend = w_shift[SAMPLE_BITS-1:0];
        end
        w_has_result = r_s2_valid &&
                       (r_s2_op == OP_EMIT || r_s2_op == OP_BLEND || r_s2_op == OP_END);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid  <= o_pop;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= w_has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_cmd    <= i_cmd;
            r_s2_op     <= r_s1_cmd.op;
            r_s2_sample <= r_s1_cmd.sample;
            r_s2_count  <= r_s1_cmd.count;
            r_s2_held   <= r_s1_held;
            r_s2_prod   <= w_prod;
            r_out_end   <= (r_s2_op == OP_END);
            r_out_count <= (r_s2_op == OP_END) ? r_s2_count : '0;
            case (r_s2_op)
                OP_BLEND: r_out_sample <= w_blend;
                OP_EMIT:  r_out_sample <= r_s2_sample;
                default:  r_out_sample <= '0;
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_end;
    assign o_m_tdata  = {{(M_DATA_W - SAMPLE_BITS - CNT_W){1'b0}}, r_out_count, r_out_sample};

endmodule

### rtl/core/audio_chunk_drop_speedup_top.sv
// top level of the audio chunk drop speedup block
// Takes one item per clock and gives results at one per clock while the output is not
// stalled. A result passes through the command queue, the registered read of the fade
// table and hold buffer, the crossfade multiply and the output register. Fade gains
// loaded through the input stream land in a 2048 x 16 fade table, held samples in a
// 16384 x 16 buffer; neither is cleared, so every fade slot used must be loaded before
// the first crossfade. The front end counts frames and channels and decides per sample
// whether it is emitted, held, crossfaded or dropped; the back end owns the memories and
// the multiplier. A four entry queue lets the front end keep accepting while the output
// waits. Configuration writes are taken at once; writes to the channel, chunk and keep
// registers restart the chunk.
module audio_chunk_drop_speedup_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [acds_pkg::S_DATA_W-1:0]  i_s_tdata,   // sample_in, gain_slot, gain_value
    input  logic [acds_pkg::KIND_W-1:0]    i_s_tuser,   // kind
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [acds_pkg::M_DATA_W-1:0]  o_m_tdata,   // sample_out, discard_count
    output logic                           o_m_tuser,   // is_end
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [acds_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [acds_pkg::CFG_W-1:0]     i_cfg_data
);
    import acds_pkg::*;

    logic       w_push, w_pop;
    t_cmd       w_push_cmd, w_head_cmd;
    t_fifo_stat w_fifo_stat;

    acds_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_fifo_stat (w_fifo_stat),
        .o_push      (w_push),
        .o_cmd       (w_push_cmd)
    );

    acds_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_stat  (w_fifo_stat)
    );

    acds_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_head_cmd),
        .i_fifo_stat (w_fifo_stat),
        .o_pop       (w_pop),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_fifo_stat.full)
        else $error("command pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_fifo_stat.empty)
        else $error("command popped from an empty queue");

    a_end_sample_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata[SAMPLE_BITS-1:0] == '0))
        else $error("end transaction carries a nonzero sample");

    a_sample_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata[SAMPLE_BITS +: CNT_W] == '0))
        else $error("sample transaction carries a nonzero discard count");

endmodule

### tb/audio_chunk_drop_speedup_top_tb.sv
// self-checking testbench for the audio chunk drop speedup block with stream stimulus
`timescale 1ns / 1ps

module audio_chunk_drop_speedup_top_tb;
    import acds_pkg::*;

    localparam logic [KIND_W-1:0]    KIND_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;
    localparam int TARGET_ITEMS = 2000;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_OFF_CYCLES = 400;

    typedef struct {
        logic [KIND_W-1:0]      kind;
        logic [SAMPLE_BITS-1:0] sample;
        logic [SLOT_W-1:0]      slot;
        logic [GAIN_W-1:0]      gain;
    } t_stream_item;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          is_end;
        logic [CNT_W-1:0]              discard_count;
    } t_speedup_res;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [S_DATA_W-1:0]  s_tdata = '0;
    logic [KIND_W-1:0]    s_tuser = '0;
    logic                 o_s_tready;
    logic                 o_m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  o_m_tdata;
    logic                 o_m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    audio_chunk_drop_speedup_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // stimulus side
    t_stream_item in_items_q[$];
    t_stream_item cur_item;
    bit           in_taken = 1'b0;
    bit           slot_written[FADE_MAX];
    int           item_total = 0;
    int           tx_idle_pct = 0;
    int           rx_idle_pct = 0;
    bit           rx_hold_off = 1'b0;
    bit           hold_off_go = 1'b0;
    int           err_count = 0;

    // predictor state
    logic [GAIN_W-1:0]             fade_tbl[FADE_MAX];
    logic signed [SAMPLE_BITS-1:0] held_buf[HELD_DEPTH];
    int                            frame_pos = 0;
    int                            chan_pos = 0;
    int                            emitted_cnt = 0;
    logic [CH_CFG_W-1:0]           cfg_channels = 4'd1;
    logic [CFG_W-1:0]              cfg_chunk = 13'd1024;
    logic [CFG_W-1:0]              cfg_keep = 13'd512;
    t_speedup_res                  speedup_out_q[$];

    function automatic int clamp_chunk(logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > CHUNK_MAX) return CHUNK_MAX;
        return v;
    endfunction

    function automatic int clamp_keep(logic [CFG_W-1:0] v, int chunk);
        if (v == 0) return 1;
        if (v > chunk) return chunk;
        return v;
    endfunction

    function automatic int fade_of(int chunk, int keep);
        int f;
        f = (keep < chunk - keep) ? keep : chunk - keep;
        if (f > FADE_MAX) f = FADE_MAX;
        return f;
    endfunction

    function automatic void restart_chunk();
        frame_pos = 0;
        chan_pos = 0;
        emitted_cnt = 0;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        case (idx)
            CFG_CHANNELS: begin
                cfg_channels = data[CH_CFG_W-1:0];
                restart_chunk();
            end
            CFG_CHUNK: begin
                cfg_chunk = data;
                restart_chunk();
            end
            CFG_KEEP: begin
                cfg_keep = data;
                restart_chunk();
            end
            default: ;
        endcase
    endfunction

    function automatic void speedup_step(t_stream_item it);
        int ch, chunk, keep, fade, hold_start, tail_start, c, j, idx;
        longint kept, tail, gl, acc, mixed;
        bit emit;
        t_speedup_res r;
        emit = 1'b0;
        r.sample_out = '0;
        r.is_end = 1'b0;
        r.discard_count = '0;
        case (it.kind)
            KIND_GAIN: begin
                fade_tbl[it.slot] = (it.gain > UNITY_GAIN) ? UNITY_GAIN : it.gain;
            end
            KIND_END: begin
                r.is_end = 1'b1;
                r.discard_count = CNT_W'(emitted_cnt);
                speedup_out_q.push_back(r);
                restart_chunk();
            end
            KIND_SAMPLE: begin
                ch = (cfg_channels == 0) ? 1 :
                     (cfg_channels > CHANNEL_MAX) ? CHANNEL_MAX : cfg_channels;
                chunk = clamp_chunk(cfg_chunk);
                keep = clamp_keep(cfg_keep, chunk);
                fade = fade_of(chunk, keep);
                hold_start = keep - fade;
                tail_start = chunk - fade;
                c = (chan_pos >= ch) ? ch - 1 : chan_pos;
                if (frame_pos < hold_start) begin
                    r.sample_out = it.sample;
                    emit = 1'b1;
                end else if (frame_pos < keep) begin
                    held_buf[(frame_pos - hold_start) * ch + c] = it.sample;
                end else if (frame_pos >= tail_start) begin
                    j = frame_pos - tail_start;
                    idx = j * ch + c;
                    kept = held_buf[idx];
                    tail = $signed(it.sample);
                    gl = fade_tbl[j];
                    acc = kept * (32768 - gl) + tail * gl;
                    mixed = (acc + 16384) >>> 15;
                    if (mixed > 32767) mixed = 32767;
                    if (mixed < -32768) mixed = -32768;
                    r.sample_out = mixed[SAMPLE_BITS-1:0];
                    emit = 1'b1;
                end
                if (emit) begin
                    speedup_out_q.push_back(r);
                    emitted_cnt++;
                end
                c++;
                if (c >= ch) begin
                    c = 0;
                    frame_pos++;
                    if (frame_pos >= chunk) begin
                        frame_pos = 0;
                        emitted_cnt = 0;
                    end
                end
                chan_pos = c;
            end
            default: ;
        endcase
    endfunction

    // input driver
    always @(negedge i_clk) begin
        if (!s_tvalid || in_taken) begin
            if (in_items_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                cur_item = in_items_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {5'b0, cur_item.gain, cur_item.slot, cur_item.sample};
                s_tuser  <= cur_item.kind;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // output ready
    always @(negedge i_clk) begin
        m_tready <= !rx_hold_off && ($urandom_range(99) >= rx_idle_pct);
    end

    // monitor and checker
    always @(posedge i_clk) begin
        t_speedup_res want;
        in_taken = i_rst_n && s_tvalid && o_s_tready;
        if (in_taken) speedup_step(cur_item);
        if (i_rst_n && o_m_tvalid && m_tready) begin
            if (speedup_out_q.size() == 0) begin
                $error("unexpected result transaction: sample_out %0d is_end %0b",
                       $signed(o_m_tdata[15:0]), o_m_tuser);
                err_count++;
            end else begin
                want = speedup_out_q.pop_front();
                if (o_m_tdata[15:0] !== want.sample_out) begin
                    $error("sample_out: expected %0d, got %0d",
                           want.sample_out, $signed(o_m_tdata[15:0]));
                    err_count++;
                end
                if (o_m_tuser !== want.is_end) begin
                    $error("is_end: expected %0b, got %0b", want.is_end, o_m_tuser);
                    err_count++;
                end
                if (o_m_tdata[30:16] !== want.discard_count) begin
                    $error("discard_count: expected %0d, got %0d",
                           want.discard_count, o_m_tdata[30:16]);
                    err_count++;
                end
            end
        end
    end

    // long receiver hold-off so the block backs up
    initial begin
        wait (hold_off_go);
        @(negedge i_clk);
        rx_hold_off = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
        rx_hold_off = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic logic [GAIN_W-1:0] rand_gain();
        if ($urandom_range(1) == 1) return GAIN_W'($urandom_range(0, 32768));
        return GAIN_W'($urandom);
    endfunction

    task automatic push_item(logic [KIND_W-1:0] kind, logic [SAMPLE_BITS-1:0] sample,
                             logic [SLOT_W-1:0] slot, logic [GAIN_W-1:0] gain);
        t_stream_item it;
        it.kind = kind;
        it.sample = sample;
        it.slot = slot;
        it.gain = gain;
        if (kind == KIND_GAIN) slot_written[slot] = 1'b1;
        if (kind != KIND_UNUSED) item_total++;
        in_items_q.push_back(it);
    endtask

    task automatic push_random_items(int n);
        int k, r;
        for (k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 87)
                push_item(KIND_SAMPLE, 16'($urandom), 11'($urandom), 16'($urandom));
            else if (r < 94)
                push_item(KIND_GAIN, 16'($urandom), 11'($urandom), rand_gain());
            else if (r < 97)
                push_item(KIND_END, 16'($urandom), 11'($urandom), 16'($urandom));
            else
                push_item(KIND_UNUSED, 16'($urandom), 11'($urandom), 16'($urandom));
        end
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (in_items_q.size() != 0 || s_tvalid || speedup_out_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_reg(idx, data);
    endtask

    task automatic end_cfg();
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(logic [CH_CFG_W-1:0] ch, logic [CFG_W-1:0] chunk,
                             logic [CFG_W-1:0] keep, int n);
        int f, s;
        wait_drained();
        write_reg(CFG_CHANNELS, {9'b0, ch});
        write_reg(CFG_CHUNK, chunk);
        write_reg(CFG_KEEP, keep);
        end_cfg();
        if (item_total < 700) begin
            tx_idle_pct = 33;
            rx_idle_pct = 46;
        end else if (item_total < 1400) begin
            tx_idle_pct = 46;
            rx_idle_pct = 33;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
        // every fade slot the tail will read must be loaded first
        f = fade_of(clamp_chunk(chunk), clamp_keep(keep, clamp_chunk(chunk)));
        for (s = 0; s < f; s++)
            if (!slot_written[s]) push_item(KIND_GAIN, 16'($urandom), 11'(s), rand_gain());
        push_random_items(n);
    endtask

    initial begin
        int chunk;
        tx_idle_pct = 33;
        rx_idle_pct = 46;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset register values: samples only reach the hold area
        push_item(KIND_GAIN, 16'h7fff, 11'd0, 16'hffff);
        push_item(KIND_GAIN, 16'h0000, 11'd2047, 16'h0000);
        push_item(KIND_UNUSED, 16'hffff, 11'h7ff, 16'hffff);
        push_item(KIND_SAMPLE, 16'h7fff, 11'd0, 16'd0);
        push_item(KIND_SAMPLE, 16'h8000, 11'd0, 16'd0);
        push_item(KIND_SAMPLE, 16'h0001, 11'd0, 16'd0);
        push_item(KIND_END, 16'd0, 11'd0, 16'd0);
        wait_drained();

        // two channels, two held frames crossfaded with extreme samples
        write_reg(CFG_CHANNELS, 13'd2);
        write_reg(CFG_CHUNK, 13'd4);
        write_reg(CFG_KEEP, 13'd2);
        end_cfg();
        push_item(KIND_GAIN, 16'd0, 11'd0, 16'd0);
        push_item(KIND_GAIN, 16'd0, 11'd1, 16'd16384);
        push_item(KIND_SAMPLE, 16'h7fff, 11'd0, 16'd0);
        push_item(KIND_SAMPLE, 16'h8000, 11'd0, 16'd0);
        push_item(KIND_SAMPLE, 16'hffff, 11'd0, 16'd0);
        push_item(KIND_SAMPLE, 16'h0000, 11'd0, 16'd0);
        push_item(KIND_SAMPLE, 16'h8000, 11'd0, 16'd0);
        push_item(KIND_SAMPLE, 16'h7fff, 11'd0, 16'd0);
        push_item(KIND_SAMPLE, 16'h0000, 11'd0, 16'd0);
        push_item(KIND_SAMPLE, 16'hffff, 11'd0, 16'd0);
        push_item(KIND_SAMPLE, 16'h1234, 11'd0, 16'd0);
        push_item(KIND_SAMPLE, 16'hedcb, 11'd0, 16'd0);
        push_item(KIND_END, 16'd0, 11'd0, 16'd0);
        wait_drained();

        // unfinished chunk with one emitted frame, unused register index keeps position
        write_reg(CFG_CHANNELS, 13'd1);
        write_reg(CFG_CHUNK, 13'd5);
        write_reg(CFG_KEEP, 13'd3);
        end_cfg();
        push_item(KIND_SAMPLE, 16'h8000, 11'd0, 16'd0);
        push_item(KIND_SAMPLE, 16'h7fff, 11'd0, 16'd0);
        wait_drained();
        write_reg(CFG_UNUSED, 13'h1fff);
        end_cfg();
        push_item(KIND_END, 16'd0, 11'd0, 16'd0);

        run_phase(4'd0, 13'd0, 13'd0, 120);
        run_phase(4'd15, 13'd6, 13'd3, 150);
        run_phase(4'd8, 13'h1fff, 13'h1fff, 250);
        hold_off_go = 1'b1;
        run_phase(4'd3, 13'd4096, 13'd4095, 150);
        run_phase(4'd1, 13'd12, 13'h1fff, 60);
        while (item_total < TARGET_ITEMS) begin
            chunk = $urandom_range(1, 20);
            run_phase(4'($urandom_range(1, 8)), 13'(chunk),
                      13'($urandom_range(0, chunk + 2)), $urandom_range(40, 120));
        end
        wait_drained();
        repeat (20) @(posedge i_clk);

        if (err_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
